FILE: src/tcst_pkg.sv
package tcst_pkg;

  // Flow table geometry: the flow index field is 10 bits and covers every entry
  localparam int FLOW_ADDR_W = 10;
  localparam int FLOW_COUNT  = 1 << FLOW_ADDR_W;
  localparam int STATE_W     = 4;

  // Bit positions in the raw TCP flag byte
  localparam int FL_FIN_BIT = 0;
  localparam int FL_SYN_BIT = 1;
  localparam int FL_RST_BIT = 2;
  localparam int FL_ACK_BIT = 4;

  typedef enum logic [STATE_W-1:0] {
    ST_CLOSED     = 4'd0,
    ST_SYN_SENT   = 4'd1,
    ST_SYN_RCVD   = 4'd2,
    ST_ESTAB      = 4'd3,
    ST_FW1        = 4'd4,
    ST_FIN_WAIT_2 = 4'd5,
    ST_CLOSE_WAIT = 4'd6,
    ST_CLOSING    = 4'd7,
    ST_LAST_ACK   = 4'd8,
    ST_TW         = 4'd9
  } tcst_state_t;

  typedef struct packed {
    logic [FLOW_ADDR_W-1:0] flow_index;
    logic [7:0]             flags;
    logic                   from_client;
  } tcst_in_t;

  typedef struct packed {
    logic [STATE_W-1:0] new_state;
    logic               changed;
    logic               is_established;
    logic               is_closed;
    logic               is_closing;
  } tcst_out_t;

  // Observer transition for one segment; codes above the last closing state are kept unless RST is set
  function automatic logic [STATE_W-1:0] tcst_next_state(
    input logic [STATE_W-1:0] cur,
    input logic [7:0]         flags,
    input logic               client
  );
    logic fin;
    logic syn;
    logic ack;
    logic [STATE_W-1:0] nxt;
    fin = flags[FL_FIN_BIT];
    syn = flags[FL_SYN_BIT];
    ack = flags[FL_ACK_BIT];
    nxt = cur;
    if (flags[FL_RST_BIT]) begin
      nxt = ST_CLOSED;
    end else begin
      case (cur)
        ST_CLOSED:     if (syn) nxt = client ? ST_SYN_SENT : ST_SYN_RCVD;
        ST_SYN_SENT:   if (syn && ack) nxt = ST_SYN_RCVD;
        ST_SYN_RCVD:   if (ack) nxt = ST_ESTAB;
        ST_ESTAB:      if (fin) nxt = client ? ST_FW1 : ST_CLOSE_WAIT;
        ST_FW1: begin
          // ACK wins over FIN here
          if (ack) nxt = ST_FIN_WAIT_2;
          else if (fin) nxt = ST_CLOSING;
        end
        ST_FIN_WAIT_2: if (fin) nxt = ST_TW;
        ST_CLOSE_WAIT: if (fin) nxt = ST_LAST_ACK;
        ST_CLOSING:    if (ack) nxt = ST_TW;
        ST_LAST_ACK:   if (ack) nxt = ST_CLOSED;
        default:       nxt = cur;
      endcase
    end
    return nxt;
  endfunction

endpackage

FILE: src/tcst_flow_store.sv
module tcst_flow_store
  import tcst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [FLOW_ADDR_W-1:0] rd_addr,
  output logic [STATE_W-1:0]     rd_data,
  input  logic                   wr_en,
  input  logic [FLOW_ADDR_W-1:0] wr_addr,
  input  logic [STATE_W-1:0]     wr_data,
  output logic                   clearing
);

  logic [STATE_W-1:0]     mem [FLOW_COUNT];
  logic [STATE_W-1:0]     rd_data_r;
  logic [FLOW_ADDR_W-1:0] clr_cnt_r;
  logic [FLOW_ADDR_W-1:0] clr_cnt_nxt;
  logic                   clearing_r;
  logic                   clearing_nxt;

  // Advance the clearing sweep, one entry per cycle after reset
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clearing_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  // Write port: sweep writes CLOSED, otherwise the updated flow state
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= ST_CLOSED;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

FILE: src/tcp_connection_state_tracker_unit.sv
// Channel   Ports                          Handshake
// input     start, busy, in_item           taken when start is high and busy low
// result    out_valid, out_item            one-cycle strobe, no backpressure
//
// The result strobe of an item follows its accepting edge through the flow
// table read register, then the transition into the result register. A new
// item may be accepted in every cycle while busy is low; a same-flow item
// right behind another takes the forwarded state instead of the table read.
// After reset the flow table is swept to CLOSED, one entry a cycle, over all
// 1024 entries, with busy held high. The result side cannot stall the block.
module tcp_connection_state_tracker_unit
  import tcst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tcst_in_t  in_item,
  output logic      out_valid,
  output tcst_out_t out_item
);

  logic               accept;
  logic               clearing;
  logic [STATE_W-1:0] rd_state;

  logic               s1_vld_r;
  tcst_in_t           s1_item_r;
  logic               fwd_hit_r;
  logic               fwd_hit_nxt;
  logic [STATE_W-1:0] fwd_state_r;

  logic [STATE_W-1:0] cur_state;
  logic [STATE_W-1:0] nxt_state;
  tcst_out_t          result_nxt;

  logic               out_valid_r;
  tcst_out_t          out_item_r;

  assign busy   = clearing;
  assign accept = start && !clearing;

  tcst_flow_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_item.flow_index),
    .rd_data  (rd_state),
    .wr_en    (s1_vld_r),
    .wr_addr  (s1_item_r.flow_index),
    .wr_data  (nxt_state),
    .clearing (clearing)
  );

  // Forward the state being written when the next item hits the same flow
  assign fwd_hit_nxt = s1_vld_r && (s1_item_r.flow_index == in_item.flow_index);

  // Apply the transition to the current flow state
  always_comb begin
    cur_state = fwd_hit_r ? fwd_state_r : rd_state;
    nxt_state = tcst_next_state(cur_state, s1_item_r.flags, s1_item_r.from_client);
    result_nxt.new_state      = nxt_state;
    result_nxt.changed        = (nxt_state != cur_state);
    result_nxt.is_established = (nxt_state == ST_ESTAB);
    result_nxt.is_closed      = (nxt_state == ST_CLOSED);
    result_nxt.is_closing     = (nxt_state >= ST_FW1) && (nxt_state <= ST_TW);
  end

  // Hold the accepted item beside the table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r   <= in_item;
      fwd_hit_r   <= fwd_hit_nxt;
      fwd_state_r <= nxt_state;
    end
  end

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every accepted item reaches the work stage next cycle
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_vld_r)
    else $error("accepted item did not reach the work stage");

  // Every item in the work stage produces a result strobe
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> out_valid)
    else $error("work-stage item produced no result");

  // A forwarding hit only follows an item that was in the work stage
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && fwd_hit_r) |-> $past(s1_vld_r))
    else $error("forwarded state without a preceding item");

  // The clearing sweep ends once and never restarts without reset
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("flow table clearing restarted");

endmodule

FILE: tb/sv/tcp_connection_state_tracker_unit_test.sv
module tcp_connection_state_tracker_unit_test
  import tcst_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT = 1750;
  localparam int HOT_FLOWS  = 8;
  localparam int TAIL_WAIT  = 8;
  localparam int DRAIN_MAX  = 1000;

  localparam logic [7:0] F_FIN     = 8'h01 << FL_FIN_BIT;
  localparam logic [7:0] F_SYN     = 8'h01 << FL_SYN_BIT;
  localparam logic [7:0] F_RST     = 8'h01 << FL_RST_BIT;
  localparam logic [7:0] F_ACK     = 8'h01 << FL_ACK_BIT;
  localparam logic [7:0] F_IGNORED = ~(F_FIN | F_SYN | F_RST | F_ACK);

  // One row of the directed table; typed rows carry their result literally
  typedef struct packed {
    logic [FLOW_ADDR_W-1:0] flow_index;
    logic [7:0]             flags;
    logic                   from_client;
    logic                   typed;
    tcst_out_t              result;
  } segment_row_t;

  localparam int ROW_COUNT = 25;
  localparam tcst_out_t CLOSED_SAME = '{ST_CLOSED, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam tcst_out_t CLOSED_NEW  = '{ST_CLOSED, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam tcst_out_t NO_RESULT   = '0;

  segment_row_t segment_rows [ROW_COUNT] = '{
    // fresh table, then the extremes of flow and flags
    '{10'd0,    8'h00,                   1'b1, 1'b1, CLOSED_SAME},
    '{10'd1023, 8'hFF,                   1'b0, 1'b1, CLOSED_SAME},
    '{10'd1023, 8'h00,                   1'b1, 1'b1, CLOSED_SAME},
    // client opens, client closes first, ACK beats FIN in the first FIN wait
    '{10'd5,    F_SYN,                   1'b1, 1'b0, NO_RESULT},
    '{10'd5,    F_SYN | F_ACK,           1'b0, 1'b0, NO_RESULT},
    '{10'd5,    F_ACK,                   1'b1, 1'b0, NO_RESULT},
    '{10'd5,    F_FIN,                   1'b1, 1'b0, NO_RESULT},
    '{10'd5,    F_FIN | F_ACK,           1'b0, 1'b0, NO_RESULT},
    '{10'd5,    F_FIN,                   1'b0, 1'b0, NO_RESULT},
    '{10'd5,    F_SYN | F_ACK | F_FIN,   1'b1, 1'b0, NO_RESULT},
    '{10'd5,    8'hFF,                   1'b1, 1'b1, CLOSED_NEW},
    // server opens, server closes first, ignored flag bits set
    '{10'd1023, F_SYN,                   1'b0, 1'b0, NO_RESULT},
    '{10'd1023, F_ACK | F_IGNORED,       1'b1, 1'b0, NO_RESULT},
    '{10'd1023, F_FIN,                   1'b0, 1'b0, NO_RESULT},
    '{10'd1023, F_ACK,                   1'b1, 1'b0, NO_RESULT},
    '{10'd1023, F_FIN,                   1'b1, 1'b0, NO_RESULT},
    '{10'd1023, F_ACK,                   1'b0, 1'b0, NO_RESULT},
    // simultaneous close through CLOSING
    '{10'd512,  F_SYN,                   1'b1, 1'b0, NO_RESULT},
    '{10'd512,  F_SYN,                   1'b0, 1'b0, NO_RESULT},
    '{10'd512,  F_SYN | F_ACK,           1'b0, 1'b0, NO_RESULT},
    '{10'd512,  F_ACK,                   1'b1, 1'b0, NO_RESULT},
    '{10'd512,  F_FIN,                   1'b1, 1'b0, NO_RESULT},
    '{10'd512,  F_FIN,                   1'b0, 1'b0, NO_RESULT},
    '{10'd512,  F_ACK,                   1'b1, 1'b0, NO_RESULT},
    '{10'd512,  F_RST | F_ACK,           1'b0, 1'b1, CLOSED_NEW}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  tcst_in_t  in_item;
  logic      out_valid;
  tcst_out_t out_item;

  tcst_state_t flow_track [FLOW_COUNT];
  tcst_out_t   awaited_updates [$];
  tcst_out_t   oldest_update;
  int          err_count = 0;

  tcp_connection_state_tracker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one segment to the tracked copy of the flow table
  function automatic tcst_out_t track_segment(tcst_in_t seg);
    tcst_state_t was;
    tcst_state_t now_st;
    logic        fin;
    logic        syn;
    logic        ack;
    tcst_out_t   r;
    was = flow_track[seg.flow_index];
    fin = seg.flags[FL_FIN_BIT];
    syn = seg.flags[FL_SYN_BIT];
    ack = seg.flags[FL_ACK_BIT];
    now_st = was;
    if (seg.flags[FL_RST_BIT]) begin
      now_st = ST_CLOSED;
    end else begin
      case (was)
        ST_CLOSED: begin
          if (syn) now_st = seg.from_client ? ST_SYN_SENT : ST_SYN_RCVD;
        end
        ST_SYN_SENT: begin
          if (syn && ack) now_st = ST_SYN_RCVD;
        end
        ST_SYN_RCVD: begin
          if (ack) now_st = ST_ESTAB;
        end
        ST_ESTAB: begin
          if (fin) now_st = seg.from_client ? ST_FW1 : ST_CLOSE_WAIT;
        end
        ST_FW1: begin
          if (ack) now_st = ST_FIN_WAIT_2;
          else if (fin) now_st = ST_CLOSING;
        end
        ST_FIN_WAIT_2: begin
          if (fin) now_st = ST_TW;
        end
        ST_CLOSE_WAIT: begin
          if (fin) now_st = ST_LAST_ACK;
        end
        ST_CLOSING: begin
          if (ack) now_st = ST_TW;
        end
        ST_LAST_ACK: begin
          if (ack) now_st = ST_CLOSED;
        end
        default: begin
          now_st = was;
        end
      endcase
    end
    flow_track[seg.flow_index] = now_st;
    r.new_state      = now_st;
    r.changed        = (now_st != was);
    r.is_established = (now_st == ST_ESTAB);
    r.is_closed      = (now_st == ST_CLOSED);
    r.is_closing     = (now_st >= ST_FW1) && (now_st <= ST_TW);
    return r;
  endfunction

  // Pick flags that move a flow one step along its normal lifecycle
  function automatic logic [7:0] advancing_flags(tcst_state_t st);
    case (st)
      ST_CLOSED:     return F_SYN;
      ST_SYN_SENT:   return F_SYN | F_ACK;
      ST_SYN_RCVD:   return F_ACK;
      ST_ESTAB:      return F_FIN;
      ST_FW1: begin
        case ($urandom_range(2))
          0:       return F_ACK;
          1:       return F_FIN;
          default: return F_FIN | F_ACK;
        endcase
      end
      ST_FIN_WAIT_2: return F_FIN;
      ST_CLOSE_WAIT: return F_FIN;
      ST_CLOSING:    return F_ACK;
      ST_LAST_ACK:   return F_ACK;
      default:       return F_RST | ($urandom_range(1) ? F_ACK : 8'h00);
    endcase
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Idle for a while, then hold the item until the block takes it
  task automatic send_segment(input tcst_in_t seg, input int idle,
                              input logic typed, input tcst_out_t typed_result);
    tcst_out_t predicted;
    repeat (idle) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= seg;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = track_segment(seg);
    awaited_updates.push_back(typed ? typed_result : predicted);
  endtask

  // Drop start and hold off until every pending update has arrived or the limit is reached
  task automatic wait_for_updates(input int limit);
    int n;
    n = 0;
    @(negedge clk);
    start <= 1'b0;
    while (awaited_updates.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Compare each result strobe with the oldest pending update
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (awaited_updates.size() == 0) begin
        $error("result with nothing pending: state %0d", out_item.new_state);
        err_count++;
      end else begin
        oldest_update = awaited_updates.pop_front();
        check_field("new_state", oldest_update.new_state, out_item.new_state);
        check_field("changed", 4'(oldest_update.changed), 4'(out_item.changed));
        check_field("is_established", 4'(oldest_update.is_established),
                    4'(out_item.is_established));
        check_field("is_closed", 4'(oldest_update.is_closed),
                    4'(out_item.is_closed));
        check_field("is_closing", 4'(oldest_update.is_closing),
                    4'(out_item.is_closing));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    tcst_in_t               seg;
    logic [FLOW_ADDR_W-1:0] hot [HOT_FLOWS];
    logic [FLOW_ADDR_W-1:0] last_flow;
    int                     roll;
    int                     burst_left;
    int                     gap;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    for (int f = 0; f < FLOW_COUNT; f++) flow_track[f] = ST_CLOSED;

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back to exercise same-flow forwarding
    for (int i = 0; i < ROW_COUNT; i++) begin
      seg.flow_index  = segment_rows[i].flow_index;
      seg.flags       = segment_rows[i].flags;
      seg.from_client = segment_rows[i].from_client;
      send_segment(seg, 0, segment_rows[i].typed, segment_rows[i].result);
    end
    wait_for_updates(DRAIN_MAX * 100);

    // Random traffic: mostly well-formed lifecycles on a few hot flows
    for (int h = 0; h < HOT_FLOWS; h++) hot[h] = FLOW_ADDR_W'($urandom);
    last_flow  = hot[0];
    burst_left = 0;
    for (int i = 0; i < ITEM_COUNT; i++) begin
      roll = $urandom_range(99);
      if (roll < 20) seg.flow_index = last_flow;
      else if (roll < 75) seg.flow_index = hot[$urandom_range(HOT_FLOWS - 1)];
      else seg.flow_index = FLOW_ADDR_W'($urandom);
      seg.from_client = 1'($urandom);

      roll = $urandom_range(99);
      if (roll < 65) begin
        seg.flags = advancing_flags(flow_track[seg.flow_index]);
        if ($urandom_range(3) == 0) seg.flags |= 8'($urandom) & F_IGNORED;
      end else if (roll < 90) begin
        seg.flags = 8'($urandom) & ~F_RST;
      end else begin
        seg.flags = 8'($urandom);
      end
      last_flow = seg.flow_index;

      // Stretches without gaps every few hundred items
      if (i % 200 == 0) burst_left = 50;
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = pick_gap();
      end
      send_segment(seg, gap, 1'b0, NO_RESULT);

      if (i % 500 == 499) wait_for_updates(DRAIN_MAX * 100);
    end

    // Drain, then let the pipeline settle
    wait_for_updates(DRAIN_MAX);
    repeat (TAIL_WAIT) @(posedge clk);
    if (awaited_updates.size() != 0) begin
      $error("%0d updates never arrived", awaited_updates.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: tcp_connection_state_tracker_unit.f
src/tcst_pkg.sv
src/tcst_flow_store.sv
src/tcp_connection_state_tracker_unit.sv
tb/sv/tcp_connection_state_tracker_unit_test.sv
